// ----- sv/ntwa_pkg.sv -----
// Package for the neighbour table with aging: widths, defaults, the token that
// walks the cell chain and the broadcast bundle from the controller.
// No dependencies.
package ntwa_pkg;

	localparam int MAX_NEIGHBOURS_DEF = 16;
	localparam int ID_W               = 32;
	localparam int IVL_W              = 16;
	localparam int LIFE_W             = 18;

	// Token handed from cell to cell, one cell per cycle
	typedef struct packed {
		logic active;      // token present in this stage
		logic func;        // 0 = hello, 1 = tick
		logic hit;         // a live entry with the key has been seen
		logic free_found;  // a free entry has been claimed upstream
		logic any_valid;   // live entry seen (after the op for a tick)
		logic flood;       // tick removed an entry
	} ntwa_tok_t;

	// Item data held by the controller and broadcast to every cell
	typedef struct packed {
		logic [ID_W-1:0]   key;
		logic [ID_W-1:0]   ip;
		logic [ID_W-1:0]   area;
		logic [ID_W-1:0]   mask;
		logic [IVL_W-1:0]  ivl;
		logic [LIFE_W-1:0] life;
		logic              commit;  // write the candidate entry this cycle
	} ntwa_bcast_t;

	typedef struct packed {
		logic is_new;
		logic flood_needed;
		logic table_full;
		logic table_empty;
	} ntwa_res_t;

	// Dead interval: three times the hello interval
	function automatic logic [LIFE_W-1:0] life_of(input logic [IVL_W-1:0] ivl);
		return {2'b00, ivl} + {1'b0, ivl, 1'b0};
	endfunction

endpackage

// ----- sv/ntwa_in_if.sv -----
// Input channel of the neighbour table: valid/ready plus hello or tick fields.
// Depends on nothing.
interface ntwa_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] nbr_id;
	logic [31:0] source_ip;
	logic [31:0] area_id;
	logic [31:0] net_mask;
	logic [15:0] hello_interval;

	modport source (output valid, func, nbr_id, source_ip, area_id, net_mask,
		hello_interval, input ready);
	modport sink (input valid, func, nbr_id, source_ip, area_id, net_mask,
		hello_interval, output ready);
endinterface

// ----- sv/ntwa_out_if.sv -----
// Result channel of the neighbour table: valid/ready plus the four status flags.
// Depends on nothing.
interface ntwa_out_if;
	logic valid;
	logic ready;
	logic is_new;
	logic flood_needed;
	logic table_full;
	logic table_empty;

	modport source (output valid, is_new, flood_needed, table_full, table_empty,
		input ready);
	modport sink (input valid, is_new, flood_needed, table_full, table_empty,
		output ready);
endinterface

// ----- sv/ntwa_cell.sv -----
// One neighbour entry of the table chain: key compare, free-slot claim, aging.
// Depends on ntwa_pkg.
module ntwa_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  ntwa_pkg::ntwa_tok_t   tok_in,
	output ntwa_pkg::ntwa_tok_t   tok_out,
	input  ntwa_pkg::ntwa_bcast_t bc,
	output logic                cand
);

	logic                          valid_q;
	logic                          cand_q;
	ntwa_pkg::ntwa_tok_t           tok_q;
	logic [ntwa_pkg::ID_W-1:0]     rid_q;
	logic [ntwa_pkg::ID_W-1:0]     ip_q;
	logic [ntwa_pkg::ID_W-1:0]     area_q;
	logic [ntwa_pkg::ID_W-1:0]     mask_q;
	logic [ntwa_pkg::IVL_W-1:0]    ivl_q;
	logic [ntwa_pkg::LIFE_W-1:0]   life_q;

	ntwa_pkg::ntwa_tok_t tok_nx;
	logic hit_here, claim_here, expire, dec, write_here;

	// Per-entry decisions as the token passes
	always_comb begin
		hit_here   = tok_in.active && !tok_in.func && valid_q && !tok_in.hit &&
			(rid_q == bc.key);
		claim_here = tok_in.active && !tok_in.func && !valid_q && !tok_in.free_found;
		expire     = tok_in.active && tok_in.func && valid_q &&
			(life_q == '0);
		dec        = tok_in.active && tok_in.func && valid_q &&
			(life_q != '0);
		write_here = bc.commit && cand_q;

		tok_nx = tok_in;
		if (hit_here)   tok_nx.hit = 1'b1;
		if (claim_here) tok_nx.free_found = 1'b1;
		if (expire)     tok_nx.flood = 1'b1;
		if (tok_in.active)
			tok_nx.any_valid = tok_in.any_valid | (tok_in.func ? dec : valid_q);
	end

	// Control: live flag, candidate mark, token stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cand_q  <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_nx;
			if (write_here)
				valid_q <= 1'b1;
			else if (expire)
				valid_q <= 1'b0;
			if (write_here)
				cand_q <= 1'b0;
			else if (tok_in.active)
				cand_q <= claim_here;
		end
	end

	// Entry contents
	always_ff @(posedge clk) begin
		if (write_here) begin
			rid_q  <= bc.key;
			ip_q   <= bc.ip;
			area_q <= bc.area;
			mask_q <= bc.mask;
			ivl_q  <= bc.ivl;
		end
		if (write_here || hit_here)
			life_q <= bc.life;
		else if (dec)
			life_q <= life_q - ntwa_pkg::LIFE_W'(1);
	end

	assign tok_out = tok_q;
	assign cand    = cand_q;

	// Stored address fields are held for the entry but not reported
	logic unused_fields;
	assign unused_fields = ^{ip_q, area_q, mask_q, ivl_q};

endmodule

// ----- sv/ntwa_ctrl.sv -----
// Controller: takes one item, launches its token down the chain, commits an
// insertion and registers the result. Depends on ntwa_pkg and the interfaces.
module ntwa_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	ntwa_in_if.sink               item,
	ntwa_out_if.source            result,
	output ntwa_pkg::ntwa_tok_t   tok_first,
	input  ntwa_pkg::ntwa_tok_t   tok_last,
	output ntwa_pkg::ntwa_bcast_t bc
);

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_HOLD} state_t;

	state_t              state_q;
	logic                start_q;
	logic                out_valid_q;
	logic                func_q;
	ntwa_pkg::ntwa_bcast_t bc_q;
	ntwa_pkg::ntwa_res_t res_q;
	ntwa_pkg::ntwa_res_t out_q;

	ntwa_pkg::ntwa_res_t res_nx;
	logic slot_free, commit, accept, hello_miss, out_load;

	// Result of the finished pass
	always_comb begin
		accept      = item.valid && item.ready;
		slot_free   = !out_valid_q || result.ready;
		hello_miss  = !tok_last.func && !tok_last.hit;
		commit      = tok_last.active && hello_miss && tok_last.free_found;
		out_load    = slot_free && ((state_q == S_RUN && tok_last.active) ||
			state_q == S_HOLD);
		res_nx.is_new       = hello_miss && tok_last.free_found;
		res_nx.table_full   = hello_miss && !tok_last.free_found;
		res_nx.flood_needed = tok_last.func && tok_last.flood;
		res_nx.table_empty  = !(tok_last.any_valid || res_nx.is_new);
	end

	// State and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= accept;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_RUN;
				end
				S_RUN: begin
					if (tok_last.active) begin
						if (slot_free)
							state_q <= S_IDLE;
						else
							state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item and result data
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q      <= item.func;
			bc_q.key    <= item.nbr_id;
			bc_q.ip     <= item.source_ip;
			bc_q.area   <= item.area_id;
			bc_q.mask   <= item.net_mask;
			bc_q.ivl    <= item.hello_interval;
			bc_q.life   <= ntwa_pkg::life_of(item.hello_interval);
			bc_q.commit <= 1'b0;
		end
		if (tok_last.active)
			res_q <= res_nx;
		if (state_q == S_RUN && tok_last.active && slot_free)
			out_q <= res_nx;
		else if (state_q == S_HOLD && slot_free)
			out_q <= res_q;
	end

	always_comb begin
		bc        = bc_q;
		bc.commit = commit;
		tok_first        = '0;
		tok_first.active = start_q;
		tok_first.func   = func_q;
	end

	assign item.ready          = (state_q == S_IDLE);
	assign result.valid        = out_valid_q;
	assign result.is_new       = out_q.is_new;
	assign result.flood_needed = out_q.flood_needed;
	assign result.table_full   = out_q.table_full;
	assign result.table_empty  = out_q.table_empty;

endmodule

// ----- sv/neighbour_table_with_aging.sv -----
// Neighbour table with aging: a chain of MAX_NEIGHBOURS entry cells walked by one token.
// Each item's token visits every cell in turn; a new item is taken only once the
// token has left the chain and its result has been loaded into the output register,
// so a stalled result also holds off the next item.
// Reset clears all entry valid bits at once; no clearing pass, ready after reset.
module neighbour_table_with_aging #(
	parameter int MAX_NEIGHBOURS = ntwa_pkg::MAX_NEIGHBOURS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ntwa_in_if.sink    item,
	ntwa_out_if.source result
);

	ntwa_pkg::ntwa_tok_t   tok [MAX_NEIGHBOURS+1];
	ntwa_pkg::ntwa_bcast_t bc;
	logic [MAX_NEIGHBOURS-1:0] cand;
	logic [MAX_NEIGHBOURS:0]   tok_act;

	ntwa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.result    (result),
		.tok_first (tok[0]),
		.tok_last  (tok[MAX_NEIGHBOURS]),
		.bc        (bc)
	);

	// Entry chain
	for (genvar g = 0; g < MAX_NEIGHBOURS; g++) begin : g_cell
		ntwa_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[g]),
			.tok_out (tok[g+1]),
			.bc      (bc),
			.cand    (cand[g])
		);
	end

	for (genvar g = 0; g <= MAX_NEIGHBOURS; g++) begin : g_act
		assign tok_act[g] = tok[g].active;
	end

	// One item in flight at most
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_act))
		else $error("more than one token in the chain");

	// No new item taken while a token is still walking
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> (tok_act == '0))
		else $error("ready raised with a pass in progress");

	// An insertion writes exactly one marked entry
	a_commit_one: assert property (@(posedge clk) disable iff (!arst_n)
		bc.commit |-> ($countones(cand) == 1))
		else $error("insert without a single candidate entry");

	// Result flags are mutually consistent
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.is_new && result.table_full) &&
			!(result.flood_needed && (result.is_new || result.table_full)) &&
			!(result.is_new && result.table_empty))
		else $error("inconsistent result flags");

endmodule
